// ===== rtl/asp_pkg.sv =====
// Shared types and constants for the A* shortest path engine.
// No dependencies; asp_ctrl, asp_dp and the top level use this package by scoped names.
`default_nettype none

package asp_pkg;

    localparam int NODE_W  = 5;
    localparam int VALUE_W = 16;
    localparam int COST_W  = 24;

    localparam logic [VALUE_W-1:0] NO_VALUE = 16'hFFFF;
    localparam logic [COST_W-1:0]  COST_MAX = 24'hFFFFFF;

    localparam logic [1:0] OP_LOAD_EDGE = 2'd0;
    localparam logic [1:0] OP_LOAD_HEUR = 2'd1;
    localparam logic [1:0] OP_SEARCH    = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_START,
        ST_MIN,
        ST_DECIDE,
        ST_EXPAND,
        ST_TRACE,
        ST_TRACE_WAIT,
        ST_OUT_READ,
        ST_OUT_SHOW,
        ST_FAIL
    } t_state;

    typedef struct packed {
        logic cap_in;
        logic clr_wr;
        logic ld_wr_ab;
        logic ld_wr_ba;
        logic srch_init;
        logic scan_init;
        logic scan_min;
        logic scan_exp;
        logic close_best;
        logic bt_init;
        logic bt_push;
        logic bt_follow;
        logic out_read;
        logic show_fail;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic scan_done;
        logic have;
        logic best_is_tgt;
        logic node_is_src;
        logic out_last;
    } t_sts;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {{(COST_W-VALUE_W+1){1'b0}}, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/asp_in_if.sv =====
// Request channel of the A* engine: operation, node pair and value.
// Depends on nothing.
`default_nettype none

interface asp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  node_a;
    logic [4:0]  node_b;
    logic [15:0] value;

    modport source(output valid, operation, node_a, node_b, value, input ready);
    modport sink(input valid, operation, node_a, node_b, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/asp_out_if.sv =====
// Result channel of the A* engine: path node, cost, found and last flags.
// Depends on nothing.
`default_nettype none

interface asp_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  path_node;
    logic [23:0] path_cost;
    logic        found;
    logic        last;

    modport source(output valid, path_node, path_cost, found, last, input ready);
    modport sink(input valid, path_node, path_cost, found, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/asp_ctrl.sv =====
// Sequencer of the A* engine: clear pass, loads, scans, trace and result output.
// Depends on asp_pkg; drives the datapath through t_cmd and reads t_sts.
`default_nettype none

module asp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_in_op,
    input  wire logic          i_out_ready,
    input  wire asp_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output asp_pkg::t_cmd      o_cmd
);

    asp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asp_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = asp_pkg::ST_IDLE;
            end
            asp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_in_op == asp_pkg::OP_LOAD_EDGE ||
                                 i_in_op == asp_pkg::OP_LOAD_HEUR) begin
                        n_state = asp_pkg::ST_LOAD_A;
                    end else if (i_in_op == asp_pkg::OP_SEARCH) begin
                        n_state = asp_pkg::ST_START;
                    end else begin
                        n_state = asp_pkg::ST_IDLE;
                    end
                end
            end
            asp_pkg::ST_LOAD_A: n_state = asp_pkg::ST_LOAD_B;
            asp_pkg::ST_LOAD_B: n_state = asp_pkg::ST_IDLE;
            asp_pkg::ST_START: begin
                n_state = i_sts.in_range ? asp_pkg::ST_MIN : asp_pkg::ST_FAIL;
            end
            asp_pkg::ST_MIN: begin
                if (i_sts.scan_done) n_state = asp_pkg::ST_DECIDE;
            end
            asp_pkg::ST_DECIDE: begin
                priority if (!i_sts.have) n_state = asp_pkg::ST_FAIL;
                else if (i_sts.best_is_tgt) n_state = asp_pkg::ST_TRACE;
                else n_state = asp_pkg::ST_EXPAND;
            end
            asp_pkg::ST_EXPAND: begin
                if (i_sts.scan_done) n_state = asp_pkg::ST_MIN;
            end
            asp_pkg::ST_TRACE: begin
                n_state = i_sts.node_is_src ? asp_pkg::ST_OUT_READ
                                            : asp_pkg::ST_TRACE_WAIT;
            end
            asp_pkg::ST_TRACE_WAIT: n_state = asp_pkg::ST_TRACE;
            asp_pkg::ST_OUT_READ:   n_state = asp_pkg::ST_OUT_SHOW;
            asp_pkg::ST_OUT_SHOW: begin
                if (i_out_ready) begin
                    n_state = i_sts.out_last ? asp_pkg::ST_IDLE : asp_pkg::ST_OUT_READ;
                end
            end
            asp_pkg::ST_FAIL: begin
                if (i_out_ready) n_state = asp_pkg::ST_IDLE;
            end
            default: n_state = asp_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            asp_pkg::ST_CLEAR: o_cmd.clr_wr = 1'b1;
            asp_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
            end
            asp_pkg::ST_LOAD_A: o_cmd.ld_wr_ab = 1'b1;
            asp_pkg::ST_LOAD_B: o_cmd.ld_wr_ba = 1'b1;
            asp_pkg::ST_START:  o_cmd.srch_init = i_sts.in_range;
            asp_pkg::ST_MIN:    o_cmd.scan_min = 1'b1;
            asp_pkg::ST_DECIDE: begin
                o_cmd.scan_init  = 1'b1;
                o_cmd.close_best = i_sts.have;
                o_cmd.bt_init    = i_sts.have && i_sts.best_is_tgt;
            end
            asp_pkg::ST_EXPAND: begin
                o_cmd.scan_exp  = 1'b1;
                o_cmd.scan_init = i_sts.scan_done;
            end
            asp_pkg::ST_TRACE:      o_cmd.bt_push = 1'b1;
            asp_pkg::ST_TRACE_WAIT: o_cmd.bt_follow = 1'b1;
            asp_pkg::ST_OUT_READ:   o_cmd.out_read = 1'b1;
            asp_pkg::ST_OUT_SHOW:   o_out_valid = 1'b1;
            asp_pkg::ST_FAIL: begin
                o_out_valid     = 1'b1;
                o_cmd.show_fail = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/asp_dp.sv =====
// Datapath of the A* engine: weight and estimate stores, node tables,
// scan pipeline, path trace and result fields. Depends on asp_pkg.
`default_nettype none

module asp_dp #(
    parameter int NODE_COUNT = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire asp_pkg::t_cmd i_cmd,
    output asp_pkg::t_sts      o_sts,
    input  wire logic [1:0]    i_op,
    input  wire logic [4:0]    i_node_a,
    input  wire logic [4:0]    i_node_b,
    input  wire logic [15:0]   i_value,
    output logic [4:0]         o_path_node,
    output logic [23:0]        o_path_cost,
    output logic               o_found,
    output logic               o_last
);

    localparam int IW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW    = $clog2(NODE_COUNT + 1);
    localparam int DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
        return AW'(row) * AW'(NODE_COUNT) + AW'(col);
    endfunction

    logic [1:0]  r_op;
    logic [4:0]  r_a, r_b;
    logic [15:0] r_val;

    logic [15:0] m_edge  [DEPTH];
    logic [15:0] m_heur  [DEPTH];
    logic [23:0] m_cost  [NODE_COUNT];
    logic [IW-1:0] m_par   [NODE_COUNT];
    logic [IW-1:0] m_trail [NODE_COUNT];

    logic [AW-1:0] r_clr_addr;
    logic [CW-1:0] r_idx;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic          r_have;
    logic [IW-1:0] r_best;
    logic [23:0]   r_best_f, r_best_g;
    logic [NODE_COUNT-1:0] r_open, r_closed;
    logic [15:0]   r_edge_q, r_heur_q;
    logic [23:0]   r_cost_q;
    logic [IW-1:0] r_par_q, r_trail_q;
    logic [IW-1:0] r_node;
    logic [CW-1:0] r_cnt;

    logic          w_in_range, w_idx_ok, w_ld, w_wr_edge, w_wr_heur, w_upd, w_skip, w_better;
    logic [IW-1:0] w_src, w_tgt, w_idx;
    logic [AW-1:0] w_wr_addr;
    logic [15:0]   w_wr_data;
    logic [23:0]   w_f, w_ng;

    assign w_src      = IW'(r_a);
    assign w_tgt      = IW'(r_b);
    assign w_idx      = r_idx[IW-1:0];
    assign w_idx_ok   = r_idx < CW'(NODE_COUNT);
    assign w_in_range = (7'(r_a) < 7'(NODE_COUNT)) && (7'(r_b) < 7'(NODE_COUNT));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op  <= i_op;
            r_a   <= i_node_a;
            r_b   <= i_node_b;
            r_val <= i_value;
        end
    end

    assign w_ld      = (i_cmd.ld_wr_ab || i_cmd.ld_wr_ba) && w_in_range;
    assign w_wr_edge = i_cmd.clr_wr || (w_ld && r_op == asp_pkg::OP_LOAD_EDGE);
    assign w_wr_heur = i_cmd.clr_wr || (w_ld && r_op == asp_pkg::OP_LOAD_HEUR);
    assign w_wr_addr = i_cmd.clr_wr   ? r_clr_addr :
                       i_cmd.ld_wr_ab ? f_addr(w_src, w_tgt) : f_addr(w_tgt, w_src);
    assign w_wr_data = i_cmd.clr_wr ? asp_pkg::NO_VALUE : r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_edge) m_edge[w_wr_addr] <= w_wr_data;
        if (i_cmd.scan_exp && w_idx_ok) r_edge_q <= m_edge[f_addr(r_best, w_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_heur) m_heur[w_wr_addr] <= w_wr_data;
        if (i_cmd.scan_min && w_idx_ok) r_heur_q <= m_heur[f_addr(w_idx, w_tgt)];
    end

    assign w_skip = (r_pidx == r_best) || (r_edge_q == asp_pkg::NO_VALUE) || r_closed[r_pidx];
    assign w_ng   = asp_pkg::sat_add(r_best_g, r_edge_q);
    assign w_upd  = i_cmd.scan_exp && r_pv && !w_skip &&
                    (!r_open[r_pidx] || w_ng < r_cost_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            m_cost[w_src] <= '0;
        end else if (w_upd) begin
            m_cost[r_pidx] <= w_ng;
        end
        if ((i_cmd.scan_min || i_cmd.scan_exp) && w_idx_ok) r_cost_q <= m_cost[w_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) m_par[r_pidx] <= r_best;
        if (i_cmd.bt_push) r_par_q <= m_par[r_node];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bt_push) m_trail[r_cnt[IW-1:0]] <= r_node;
        if (i_cmd.out_read) r_trail_q <= m_trail[IW'(r_cnt - CW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_pv  <= 1'b0;
        end else if (i_cmd.srch_init || i_cmd.scan_init) begin
            r_idx <= '0;
            r_pv  <= 1'b0;
        end else if (i_cmd.scan_min || i_cmd.scan_exp) begin
            r_pv <= w_idx_ok;
            if (w_idx_ok) r_idx <= r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.scan_min || i_cmd.scan_exp) && w_idx_ok) r_pidx <= w_idx;
    end

    assign w_f      = asp_pkg::sat_add(r_cost_q, r_heur_q);
    assign w_better = i_cmd.scan_min && r_pv && r_open[r_pidx] && (!r_have || w_f < r_best_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.srch_init || i_cmd.scan_init) begin
            r_have <= 1'b0;
        end else if (w_better) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_better) begin
            r_best   <= r_pidx;
            r_best_f <= w_f;
            r_best_g <= r_cost_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= '0;
            r_closed <= '0;
        end else if (i_cmd.srch_init) begin
            r_open   <= NODE_COUNT'(1) << w_src;
            r_closed <= '0;
        end else if (i_cmd.close_best) begin
            r_open[r_best]   <= 1'b0;
            r_closed[r_best] <= 1'b1;
        end else if (w_upd) begin
            r_open[r_pidx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.bt_init) begin
            r_cnt <= '0;
        end else if (i_cmd.bt_push) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.out_read) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bt_init) begin
            r_node <= r_best;
        end else if (i_cmd.bt_follow) begin
            r_node <= r_par_q;
        end
    end

    always_comb begin
        o_sts.clr_last    = r_clr_addr == AW'(DEPTH - 1);
        o_sts.in_range    = w_in_range;
        o_sts.scan_done   = !w_idx_ok && !r_pv;
        o_sts.have        = r_have;
        o_sts.best_is_tgt = r_best == w_tgt;
        o_sts.node_is_src = r_node == w_src;
        o_sts.out_last    = r_cnt == '0;
    end

    assign o_path_node = i_cmd.show_fail ? 5'd0 : 5'(r_trail_q);
    assign o_path_cost = i_cmd.show_fail ? 24'd0 : r_best_g;
    assign o_found     = !i_cmd.show_fail;
    assign o_last      = i_cmd.show_fail || (r_cnt == '0);

endmodule

`default_nettype wire

// ===== rtl/astar_shortest_path.sv =====
// Top level of the A* shortest path engine: sequencer plus datapath.
// Depends on asp_pkg, asp_in_if, asp_out_if, asp_ctrl and asp_dp.
//
//   channel  | dir | payload                                  | items
//   i_req    | in  | operation, node_a, node_b, value         | one per request
//   o_rsp    | out | path_node, path_cost, found, last        | 0, 1 or path length
//
// Load item: the engine writes both halves of the symmetric pair, in ST_LOAD_A and ST_LOAD_B.
// Search: each expanded node takes a minimum scan and an expand scan, the trace then visits
// each path node, and each result is read and then shown; the single read port on the node
// table paces every scan. After reset a clearing pass fills both stores with NO_VALUE.
// i_req.ready is high only between items; results wait in place while o_rsp.ready is low.
`default_nettype none

module astar_shortest_path #(
    parameter int NODE_COUNT = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    asp_in_if.sink    i_req,
    asp_out_if.source o_rsp
);

    asp_pkg::t_cmd cmd;
    asp_pkg::t_sts sts;

    asp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_op     (i_req.operation),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    asp_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_req.operation),
        .i_node_a    (i_req.node_a),
        .i_node_b    (i_req.node_b),
        .i_value     (i_req.value),
        .o_path_node (o_rsp.path_node),
        .o_path_cost (o_rsp.path_cost),
        .o_found     (o_rsp.found),
        .o_last      (o_rsp.last)
    );

endmodule

`default_nettype wire

// ===== rtl/asp_checker.sv =====
// Port-level checks for the A* engine, bound to the top level.
// Depends only on the top level's channel signals.
`default_nettype none

module asp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [4:0]  i_path_node,
    input wire logic [23:0] i_path_cost,
    input wire logic        i_found,
    input wire logic        i_last
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("request taken while a result is pending");

    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> i_last)
        else $error("failed search result not marked last");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_path_node == 5'd0 && i_path_cost == 24'd0))
        else $error("failed search result carries nonzero fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_path_node) && $stable(i_path_cost) &&
             $stable(i_found) && $stable(i_last)))
        else $error("stalled result changed");

    a_cost_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) |=>
            (!i_in_ready && (!i_out_valid || $stable(i_path_cost))))
        else $error("path cost changed within one search");

endmodule

bind astar_shortest_path asp_checker u_asp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_path_node (o_rsp.path_node),
    .i_path_cost (o_rsp.path_cost),
    .i_found     (o_rsp.found),
    .i_last      (o_rsp.last)
);

`default_nettype wire
